// File: hw/rtl/spr_pkg.sv
// shared types, constants and helpers for the stream pattern replace unit
package spr_pkg;

  // size limits of pattern and replacement
  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;

  // width of a length register and of a job's byte count
  localparam int LEN_W = 4;

  // number of entries in the job queue between front and back
  localparam int JOB_DEPTH = 4;

  // byte value that breaks a partial match
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  // input command codes
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PATTERN_BYTES,
    REG_PATTERN_LENGTH,
    REG_REPLACEMENT_BYTES,
    REG_REPLACEMENT_LENGTH
  } spr_reg_t;

  // where the counted bytes of a job come from
  typedef enum logic {
    SRC_PATTERN,
    SRC_REPLACEMENT
  } spr_src_t;

  // input request payload
  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } spr_in_t;

  // result request payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } spr_out_t;

  // one unit of work for the back end: count bytes from src, then an optional literal byte
  typedef struct packed {
    spr_src_t         src;
    logic [LEN_W-1:0] count;
    logic             has_byte;
    logic [7:0]       data;
  } spr_job_t;

  // byte k of a 64-bit register
  function automatic logic [7:0] byte_of(logic [63:0] word, logic [2:0] k);
    return word[{k, 3'b000} +: 8];
  endfunction

endpackage

// File: hw/rtl/spr_job_fifo.sv
// small register queue carrying jobs from the front end to the back end
module spr_job_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  // storage, written at the tail
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/spr_front.sv
// front end: accepts input requests, tracks the partial match and issues jobs
module spr_front #(
  parameter int MAX_PATTERN     = spr_pkg::MAX_PATTERN,
  parameter int MAX_REPLACEMENT = spr_pkg::MAX_REPLACEMENT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  spr_pkg::spr_in_t        item,
  input  logic                    queue_full,
  input  logic [63:0]             pattern_bytes,
  input  logic [spr_pkg::LEN_W-1:0] pattern_length,
  input  logic [spr_pkg::LEN_W-1:0] replacement_length,
  output logic                    job_push,
  output spr_pkg::spr_job_t       job
);

  import spr_pkg::*;

  localparam int MW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [MW-1:0]    matched;
  logic [MW-1:0]    matched_next;
  logic [LEN_W-1:0] plen;
  logic [LEN_W-1:0] rlen;
  logic [LEN_W-1:0] matched_ext;
  logic [7:0]       expected;
  logic             accept;

  assign accept      = push && !queue_full;
  assign matched_ext = LEN_W'(matched);
  assign expected    = byte_of(pattern_bytes, 3'(matched));

  // effective lengths after clamping
  always_comb begin
    if (pattern_length == '0) begin
      plen = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      plen = LEN_W'(MAX_PATTERN);
    end else begin
      plen = pattern_length;
    end
    if (replacement_length > LEN_W'(MAX_REPLACEMENT)) begin
      rlen = LEN_W'(MAX_REPLACEMENT);
    end else begin
      rlen = replacement_length;
    end
  end

  // classify the accepted byte and build its job
  always_comb begin
    matched_next = matched;
    job_push     = 1'b0;
    job.src      = SRC_PATTERN;
    job.count    = '0;
    job.has_byte = 1'b0;
    job.data     = item.in_byte;
    if (accept) begin
      if (item.cmd == CMD_END) begin
        // flush the held prefix
        job.count    = matched_ext;
        job_push     = (matched != '0);
        matched_next = '0;
      end else if (matched == '0) begin
        if (item.in_byte == expected) begin
          if (plen <= LEN_W'(1)) begin
            job.src   = SRC_REPLACEMENT;
            job.count = rlen;
            job_push  = (rlen != '0);
          end else begin
            matched_next = MW'(1);
          end
        end else begin
          job.has_byte = 1'b1;
          job_push     = 1'b1;
        end
      end else begin
        if (item.in_byte == NEWLINE_CODE || item.in_byte != expected) begin
          // mismatch: held prefix then the offending byte
          job.count    = matched_ext;
          job.has_byte = 1'b1;
          job_push     = 1'b1;
          matched_next = '0;
        end else if (matched_ext + LEN_W'(1) >= plen) begin
          job.src      = SRC_REPLACEMENT;
          job.count    = rlen;
          job_push     = (rlen != '0);
          matched_next = '0;
        end else begin
          matched_next = matched + 1'b1;
        end
      end
    end
  end

  // matched prefix count
  always_ff @(posedge clk) begin
    if (rst) begin
      matched <= '0;
    end else begin
      matched <= matched_next;
    end
  end

endmodule

// File: hw/rtl/spr_back.sv
// back end: expands jobs into single bytes behind an output register
module spr_back (
  input  logic              clk,
  input  logic              rst,
  input  spr_pkg::spr_job_t job,
  input  logic              job_valid,
  output logic              job_pop,
  input  logic [63:0]       pattern_bytes,
  input  logic [63:0]       replacement_bytes,
  output logic              empty,
  input  logic              pop,
  output spr_pkg::spr_out_t result
);

  import spr_pkg::*;

  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] total;
  logic             advance;
  logic             is_last;
  logic [7:0]       next_byte;
  logic             out_valid;

  assign total   = job.count + LEN_W'(job.has_byte);
  assign is_last = (idx == total - LEN_W'(1));
  assign advance = job_valid && (!out_valid || pop);
  assign job_pop = advance && is_last;
  assign empty   = !out_valid;

  // pick the byte for the current position of the job
  always_comb begin
    if (idx < job.count) begin
      if (job.src == SRC_REPLACEMENT) begin
        next_byte = byte_of(replacement_bytes, 3'(idx));
      end else begin
        next_byte = byte_of(pattern_bytes, 3'(idx));
      end
    end else begin
      next_byte = job.data;
    end
  end

  // position within the head job and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        idx       <= is_last ? '0 : idx + 1'b1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (advance) begin
      result.out_byte    <= next_byte;
      result.last_of_run <= is_last;
    end
  end

endmodule

// File: hw/rtl/stream_pattern_replace_unit.sv
// top level of the stream pattern replace unit: configuration registers and wiring
//
// Replaces every occurrence of a configured byte pattern (1 to 8 bytes) in a byte
// stream by a configured replacement (0 to 8 bytes). The front end takes one input
// request per cycle as long as its four-entry job queue has room; a byte that only
// extends a partial match, or completes one with an empty replacement, leaves no job
// and costs nothing downstream. The back end sends one result per cycle while the
// output register is free or popped; an input causes 0 to 8 results. The sustained
// input rate is one byte per cycle while each byte yields at most one result and
// results are popped as they come. A first result passes the job queue, then the output
// register. A mismatch or newline inside a match gives the held prefix followed by the
// byte itself, which is not rechecked; an end command flushes the prefix. The user
// must write configuration only while the unit is idle; this is not enforced.
module stream_pattern_replace_unit #(
  parameter int MAX_PATTERN     = spr_pkg::MAX_PATTERN,
  parameter int MAX_REPLACEMENT = spr_pkg::MAX_REPLACEMENT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  spr_pkg::spr_in_t  item,
  output logic              empty,
  input  logic              pop,
  output spr_pkg::spr_out_t result,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data
);

  import spr_pkg::*;

  logic [63:0]      pattern_bytes;
  logic [LEN_W-1:0] pattern_length;
  logic [63:0]      replacement_bytes;
  logic [LEN_W-1:0] replacement_length;

  logic             job_push;
  logic             job_pop;
  logic             job_full;
  logic             job_empty;
  spr_job_t         job_in;
  spr_job_t         job_head;

  assign full = job_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_write) begin
      unique case (spr_reg_t'(cfg_index))
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // match tracking and job issue
  spr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .item               (item),
    .queue_full         (job_full),
    .pattern_bytes      (pattern_bytes),
    .pattern_length     (pattern_length),
    .replacement_length (replacement_length),
    .job_push           (job_push),
    .job                (job_in)
  );

  // job queue between the two halves
  spr_job_fifo #(
    .WIDTH ($bits(spr_job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_head),
    .empty (job_empty)
  );

  // byte expansion and result register
  spr_back u_back (
    .clk               (clk),
    .rst               (rst),
    .job               (job_head),
    .job_valid         (!job_empty),
    .job_pop           (job_pop),
    .pattern_bytes     (pattern_bytes),
    .replacement_bytes (replacement_bytes),
    .empty             (empty),
    .pop               (pop),
    .result            (result)
  );

  // front never issues into a full queue
  assert property (@(posedge clk) disable iff (rst) !(job_push && job_full))
    else $error("job issued into a full queue");

  // back only retires a job that is present
  assert property (@(posedge clk) disable iff (rst) job_pop |-> !job_empty)
    else $error("job retired from an empty queue");

  // an issued job is waiting in the queue in the next cycle
  assert property (@(posedge clk) disable iff (rst) job_push |=> !job_empty)
    else $error("issued job lost");

endmodule

// File: test/stream_replace_checker.sv
// checker for the stream pattern replace unit: predicts the rewritten stream and compares results
module stream_replace_checker
  import spr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  spr_in_t     item,
  input  logic        empty,
  input  logic        pop,
  input  spr_out_t    result,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  // own copy of the configuration and of the match state
  logic [63:0] pat_word;
  logic [3:0]  pat_len_reg;
  logic [63:0] rep_word;
  logic [3:0]  rep_len_reg;
  logic [2:0]  held_count;

  // rewritten bytes still to come out of the unit, oldest first
  spr_out_t rewritten_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // append one byte of the rewritten stream
  function automatic void add_byte(logic [7:0] b);
    spr_out_t r;
    r.out_byte    = b;
    r.last_of_run = 1'b0;
    rewritten_q.push_back(r);
  endfunction

  // append the first count bytes of a register word
  function automatic void add_bytes(logic [63:0] word, int count);
    for (int i = 0; i < count; i++) add_byte(word[8*i +: 8]);
  endfunction

  // work out the bytes that one input request gives and advance the match state
  function automatic void rewrite_step(logic cmd, logic [7:0] b);
    int plen;
    int rlen;
    int m;
    int first;
    plen  = (pat_len_reg == 0) ? 1 : ((pat_len_reg > MAX_PATTERN) ? MAX_PATTERN : pat_len_reg);
    rlen  = (rep_len_reg > MAX_REPLACEMENT) ? MAX_REPLACEMENT : rep_len_reg;
    m     = held_count;
    first = rewritten_q.size();
    if (cmd == CMD_END) begin
      // flush the held prefix
      add_bytes(pat_word, m);
      held_count = '0;
    end else if (m == 0) begin
      // start of a possible match, only pattern byte 0 counts
      if (b == pat_word[7:0]) begin
        if (plen <= 1) add_bytes(rep_word, rlen);
        else held_count = 3'd1;
      end else begin
        add_byte(b);
      end
    end else if (b == NEWLINE_CODE || b != pat_word[8*m +: 8]) begin
      // broken match: prefix then the byte itself, not rechecked
      add_bytes(pat_word, m);
      add_byte(b);
      held_count = '0;
    end else if (m + 1 >= plen) begin
      add_bytes(rep_word, rlen);
      held_count = '0;
    end else begin
      held_count = 3'(m + 1);
    end
    if (rewritten_q.size() > first)
      rewritten_q[rewritten_q.size()-1].last_of_run = 1'b1;
  endfunction

  // watch the three ports at each edge
  always @(posedge clk) begin
    spr_out_t want;
    if (rst) begin
      pat_word    = '0;
      pat_len_reg = 4'd1;
      rep_word    = '0;
      rep_len_reg = 4'd0;
      held_count  = '0;
      rewritten_q.delete();
    end else begin
      // compare an accepted result with the oldest expectation
      if (pop && !empty) begin
        if (rewritten_q.size() == 0) begin
          $error("unexpected result: out_byte %02h last_of_run %0b",
                 result.out_byte, result.last_of_run);
          mismatches++;
        end else begin
          want = rewritten_q.pop_front();
          if (result.out_byte !== want.out_byte) begin
            $error("out_byte mismatch: expected %02h, actual %02h",
                   want.out_byte, result.out_byte);
            mismatches++;
          end
          if (result.last_of_run !== want.last_of_run) begin
            $error("last_of_run mismatch: expected %0b, actual %0b",
                   want.last_of_run, result.last_of_run);
            mismatches++;
          end
        end
      end
      // register writes
      if (cfg_write) begin
        case (spr_reg_t'(cfg_index))
          REG_PATTERN_BYTES:      pat_word    = cfg_data;
          REG_PATTERN_LENGTH:     pat_len_reg = cfg_data[3:0];
          REG_REPLACEMENT_BYTES:  rep_word    = cfg_data;
          REG_REPLACEMENT_LENGTH: rep_len_reg = cfg_data[3:0];
          default: ;
        endcase
      end
      // accepted input request
      if (push && !full) rewrite_step(item.cmd, item.in_byte);
    end
    outstanding = rewritten_q.size();
  end

endmodule

// File: test/tb_stream_pattern_replace_unit.sv
// testbench top for the stream pattern replace unit: stimulus, idling and verdict
module tb_stream_pattern_replace_unit;
  import spr_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 46;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  spr_in_t     item;
  logic        empty;
  logic        pop = 1'b0;
  spr_out_t    result;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  int          mismatches;
  int          outstanding;
  int          quiet_cycles = 0;
  int          pop_stall = 0;
  bit          calm = 1'b0;

  // pattern as the stimulus sees it, to build matching runs
  logic [63:0] stim_pat;
  int          stim_plen;

  always #10 clk = ~clk;

  stream_pattern_replace_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stream_replace_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // random pattern word, now and then with a newline byte
  function automatic logic [63:0] rand_pattern();
    logic [63:0] w;
    for (int i = 0; i < 8; i++)
      w[8*i +: 8] = ($urandom_range(0, 9) == 0) ? NEWLINE_CODE : 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic logic [63:0] rand_word();
    return {32'($urandom), 32'($urandom)};
  endfunction

  // result side: pop with random stalls
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_stall = 0;
    end else if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall--;
    end else begin
      pop <= 1'b1;
      pop_stall = pick_gap();
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // one input request, held until accepted
  task automatic send(logic cmd, logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= '{cmd, b};
    do @(posedge clk); while (full);
  endtask

  // stop sending and wait until every expected result has come out
  task automatic wait_idle(int extra);
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(spr_reg_t idx, logic [63:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // write all four registers, unit idle
  task automatic set_config(logic [63:0] pat, int plen, logic [63:0] rep, int rlen);
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, 64'(plen));
    write_reg(REG_REPLACEMENT_BYTES, rep);
    write_reg(REG_REPLACEMENT_LENGTH, 64'(rlen));
    cfg_write <= 1'b0;
    stim_pat  = pat;
    stim_plen = (plen < 1) ? 1 : ((plen > MAX_PATTERN) ? MAX_PATTERN : plen);
  endtask

  // random traffic: mostly whole or broken pattern runs, the rest noise and ends
  task automatic run_phase(int items);
    int sent;
    int r;
    int n;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        for (int k = 0; k < stim_plen; k++) send(CMD_DATA, stim_pat[8*k +: 8]);
        sent += stim_plen;
      end else if (r < 80 && stim_plen > 1) begin
        n = $urandom_range(1, stim_plen - 1);
        for (int k = 0; k < n; k++) send(CMD_DATA, stim_pat[8*k +: 8]);
        case ($urandom_range(0, 3))
          0: send(CMD_DATA, 8'($urandom_range(0, 255)));
          1: send(CMD_DATA, NEWLINE_CODE);
          2: send(CMD_END, 8'($urandom_range(0, 255)));
          default: send(CMD_DATA, stim_pat[7:0]);
        endcase
        sent += n + 1;
      end else if (r < 88) begin
        send(CMD_END, 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        send(CMD_DATA, 8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    item      = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    stim_pat  = '0;
    stim_plen = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one-byte zero pattern deleted, other bytes pass, empty end
    send(CMD_DATA, 8'h00);
    send(CMD_DATA, 8'hFF);
    send(CMD_END, 8'h5A);

    // three-byte pattern, full eight-byte replacement
    set_config(64'h0000_0000_0043_4241, 3, 64'hFFEE_DDCC_BBAA_9988, 8);
    send(CMD_DATA, 8'h41);
    send(CMD_DATA, 8'h42);
    send(CMD_DATA, 8'h43);
    // mismatch on the third byte
    send(CMD_DATA, 8'h41);
    send(CMD_DATA, 8'h42);
    send(CMD_DATA, 8'h58);
    // newline inside a match, then a newline on its own
    send(CMD_DATA, 8'h41);
    send(CMD_DATA, NEWLINE_CODE);
    send(CMD_DATA, NEWLINE_CODE);
    // end command flushes the held prefix
    send(CMD_DATA, 8'h41);
    send(CMD_DATA, 8'h42);
    send(CMD_END, 8'hA5);
    // offending byte is not taken as a new match start
    send(CMD_DATA, 8'h41);
    send(CMD_DATA, 8'h41);
    // pattern shortened while two bytes are held
    send(CMD_DATA, 8'h41);
    send(CMD_DATA, 8'h42);
    set_config(64'h0000_0000_0043_4241, 2, 64'hFFEE_DDCC_BBAA_9988, 8);
    send(CMD_DATA, 8'h43);

    // zero length read as one, oversized replacement length saturated
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h0123_4567_89AB_CDEF, 15);
    send(CMD_DATA, 8'hFF);
    send(CMD_DATA, 8'h00);
    send(CMD_END, 8'h00);

    // random phases over a spread of settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(rand_pattern(), 8, rand_word(), 8);
        1: set_config(rand_pattern(), 1, rand_word(), 0);
        2: set_config(64'hFFFF_FFFF_FFFF_FFFF, 15, 64'h0, 15);
        3: set_config(rand_pattern(), 0, rand_word(), $urandom_range(0, 8));
        default: set_config(rand_pattern(), $urandom_range(1, 8), rand_word(),
                            $urandom_range(0, 8));
      endcase
      calm = (ph == 2) || ($urandom_range(0, 4) == 0);
      run_phase(PHASE_ITEMS);
    end
    calm = 1'b0;

    // drain and verdict
    wait_idle(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
